@@ src/gaussian_mixture_classifier_macros.svh @@
// assertion macros for the checker
`ifndef GAUSSIAN_MIXTURE_CLASSIFIER_MACROS_SVH
`define GAUSSIAN_MIXTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define GMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/gmc_pkg.sv @@
package gmc_pkg;

   localparam int MAX_CLUSTERS = 8;
   localparam int CIDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int EXP_STEPS = 1024;
   localparam logic [65:0] EXP_RATIO = 66'd4228380000;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_CLASSIFY = 1'b1;

   typedef logic [15:0] exp_table_type [EXP_STEPS];

   typedef struct packed {
      logic [23:0] mean;
      logic [31:0] inv;
      logic [16:0] weight;
   } cluster_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [31:0] recip;
   } recip_status_type;

   // exp(-i/64) in q0.16, built by a q0.32 recurrence
   function automatic exp_table_type build_exp_table();
      exp_table_type tab;
      logic [65:0] t;
      logic [65:0] e;
      t = 66'd1 << 32;
      for (int i = 0; i < EXP_STEPS; i++) begin
         e = (t + 66'd32768) >> 16;
         tab[i] = (e > 66'd65535) ? 16'hFFFF : e[15:0];
         t = (t * EXP_RATIO + (66'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

@@ src/gmc_recip.sv @@
module gmc_recip
   import gmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [23:0]      divisor,
   output recip_status_type status
);

   logic [23:0] d_ff, d_in;
   logic [24:0] rem_ff, rem_in;
   logic [32:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [24:0] rem_shift;
   logic        ge;

   // restoring division of 2^32 by the divisor, one quotient bit a cycle
   always_comb begin
      rem_shift = {rem_ff[23:0], (cnt_ff == 6'd32)};
      ge = rem_shift >= {1'b0, d_ff};
      d_in = d_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         d_in = divisor;
         rem_in = '0;
         q_in = '0;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_shift - {1'b0, d_ff}) : rem_shift;
         q_in = {q_ff[31:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.recip = q_ff[32] ? 32'hFFFF_FFFF : q_ff[31:0];

endmodule

@@ src/gaussian_mixture_classifier.sv @@
// load: the transfer starts the bit-serial reciprocal divider, and the store is written when it is done
// classify: for n active clusters, one cluster read from the store per cycle
// into a six-stage scoring pipeline; zero active clusters skip the pipeline and answer directly
// one item at a time; a result may wait in the output register while the next is taken
// synchronous active-high reset clears the cluster store valid bits, control and count to 3
module gaussian_mixture_classifier
   import gmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cluster_index, cluster_mean, cluster_deviation, cluster_weight, sample
   input  logic [95:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // label
   output logic [7:0]  rsp_tdata,
   // all_scores_zero
   output logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RECIP, ST_SCORE, ST_DRAIN, ST_HOLD
   } state_type;

   state_type state_ff;
   logic [3:0] count_ff;

   logic [2:0]  f_index;
   logic [23:0] f_mean, f_dev, f_sample;
   logic [16:0] f_weight;
   assign f_index = req_tdata[2:0];
   assign f_mean = req_tdata[26:3];
   assign f_dev = req_tdata[50:27];
   assign f_weight = req_tdata[67:51];
   assign f_sample = req_tdata[91:68];

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   // reciprocal unit
   recip_status_type rstat;
   logic rstart;
   logic [23:0] rdiv;
   assign rstart = accept && (req_tuser == ACTION_LOAD);
   assign rdiv = (f_dev == 24'd0) ? 24'd1 : f_dev;
   gmc_recip u_recip (
      .clock(clock), .reset(reset), .start(rstart), .divisor(rdiv), .status(rstat)
   );

   // cluster store
   cluster_type mem [MAX_CLUSTERS];
   logic [MAX_CLUSTERS-1:0] valid_ff;
   logic [CIDX_W-1:0] wr_idx_ff;
   logic wr_ok_ff;
   logic [23:0] wr_mean_ff;
   logic [16:0] wr_weight_ff;
   logic [6:0] idx_ext;
   logic mem_we;
   cluster_type wr_entry;
   assign idx_ext = {4'b0, f_index};
   assign mem_we = (state_ff == ST_RECIP) && rstat.done && wr_ok_ff;
   assign wr_entry = '{mean: wr_mean_ff, inv: rstat.recip, weight: wr_weight_ff};

   logic [CIDX_W-1:0] issue_ff;
   logic [CIDX_W:0] n_ff;
   logic [23:0] sample_ff;
   logic issue_v, issue_last;
   assign issue_v = (state_ff == ST_SCORE);
   assign issue_last = ({1'b0, issue_ff} + 1'b1) == n_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= wr_entry;
      end
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_idx_ff] <= 1'b1;
      end
   end

   // scoring pipeline
   cluster_type rd_ff;
   logic rd_valid_ff;
   logic [5:0] v_ff, last_ff;
   logic [56:0] p_ff;
   logic [16:0] w2_ff, w3_ff, w4_ff;
   logic [31:0] inv2_ff, inv3_ff, inv4_ff, inv5_ff;
   logic [37:0] sq_ff;
   logic zero3_ff, zero4_ff;
   logic [15:0] e_ff;
   logic [31:0] we_ff;
   logic [63:0] score_ff;

   cluster_type ent;
   logic [24:0] diff;
   logic [24:0] mag;
   logic over;
   logic [18:0] z16;
   logic [32:0] wprod;

   function automatic logic [24:0] f_sx(input logic [23:0] v);
      return {v[23], v};
   endfunction

   always_comb begin
      ent = rd_valid_ff ? rd_ff : '0;
      diff = {f_sx(sample_ff)} - {ent.mean[23], ent.mean};
      mag = diff[24] ? (25'd0 - diff) : diff;
      over = p_ff >= (57'd6 << 32);
      z16 = p_ff[34:16];
      wprod = 33'(w4_ff) * 33'(e_ff);
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[issue_ff];
      rd_valid_ff <= valid_ff[issue_ff];
      p_ff <= 57'(mag) * 57'(ent.inv);
      w2_ff <= ent.weight;
      inv2_ff <= ent.inv;
      sq_ff <= 38'(z16) * 38'(z16);
      zero3_ff <= over;
      w3_ff <= w2_ff;
      inv3_ff <= inv2_ff;
      e_ff <= EXP_TABLE[sq_ff[36:27]];
      zero4_ff <= zero3_ff || sq_ff[37];
      w4_ff <= w3_ff;
      inv4_ff <= inv3_ff;
      we_ff <= zero4_ff ? 32'd0 : wprod[32:1];
      inv5_ff <= inv4_ff;
      score_ff <= 64'(we_ff) * 64'(inv5_ff);
      if (reset) begin
         v_ff <= '0;
         last_ff <= '0;
      end else begin
         v_ff <= {v_ff[4:0], issue_v};
         last_ff <= {last_ff[4:0], issue_v && issue_last};
      end
   end

   // control, compare and output
   logic [63:0] best_ff;
   logic [CIDX_W-1:0] best_k_ff, cmp_k_ff;
   logic rsp_valid_ff;
   logic [3:0] label_ff;
   logic zero_ff;
   logic [CIDX_W:0] n_in;
   logic [6:0] label_ext;
   assign n_in = ({3'b0, count_ff} > 7'(MAX_CLUSTERS)) ? (CIDX_W+1)'(MAX_CLUSTERS)
                                                        : (CIDX_W+1)'(count_ff);
   assign label_ext = 7'(best_k_ff) + 7'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 4'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if ((state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser == ACTION_LOAD) begin
                     wr_ok_ff <= idx_ext < 7'(MAX_CLUSTERS);
                     wr_idx_ff <= idx_ext[CIDX_W-1:0];
                     wr_mean_ff <= f_mean;
                     wr_weight_ff <= f_weight;
                     state_ff <= ST_RECIP;
                  end else begin
                     sample_ff <= f_sample;
                     n_ff <= n_in;
                     issue_ff <= '0;
                     cmp_k_ff <= '0;
                     best_ff <= '0;
                     best_k_ff <= '0;
                     state_ff <= (n_in == '0) ? ST_HOLD : ST_SCORE;
                  end
               end
            end
            ST_RECIP: begin
               if (rstat.done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SCORE: begin
               issue_ff <= issue_ff + 1'b1;
               if (issue_last) begin
                  state_ff <= ST_DRAIN;
               end
               // early scores arrive while later clusters are still issued
               if (v_ff[5]) begin
                  cmp_k_ff <= cmp_k_ff + 1'b1;
                  if (score_ff > best_ff) begin
                     best_ff <= score_ff;
                     best_k_ff <= cmp_k_ff;
                  end
               end
            end
            ST_DRAIN: begin
               if (v_ff[5]) begin
                  cmp_k_ff <= cmp_k_ff + 1'b1;
                  if (score_ff > best_ff) begin
                     best_ff <= score_ff;
                     best_k_ff <= cmp_k_ff;
                  end
                  if (last_ff[5]) begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  label_ff <= label_ext[3:0];
                  zero_ff <= (best_ff == 64'd0);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0, label_ff};
   assign rsp_tuser = zero_ff;

endmodule

@@ src/gmc_checker.sv @@
`include "gaussian_mixture_classifier_macros.svh"

module gmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   `GMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `GMC_ASSERT_NOW(a_label_range, clock, reset, rsp_tvalid, rsp_tdata[7:4] == 4'd0 && rsp_tdata[3:0] >= 4'd1 && rsp_tdata[3:0] <= 4'd8, "label out of range")
   `GMC_ASSERT_NOW(a_zero_label, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[3:0] == 4'd1, "all-zero result without label one")
   `GMC_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after a transfer")

endmodule

bind gaussian_mixture_classifier gmc_checker u_gmc_checker (.*);
